### hdl/utf8_string_decoder_macros.svh
// Assertion macros for the UTF-8 string decoder.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef UTF8_STRING_DECODER_MACROS_SVH
`define UTF8_STRING_DECODER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/utf8d_pkg.sv
// Shared constants and types of the UTF-8 string decoder.
// No dependencies.
`default_nettype none

package utf8d_pkg;

    localparam int MAX_BYTES = 64;
    localparam int ADDR_W    = $clog2(MAX_BYTES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int PEND_W    = 2;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BYTES);

    // Command queue between front and back (depth is a power of two).
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Byte classes.
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] L2_MASK   = 8'he0;
    localparam logic [7:0] L2_TAG    = 8'hc0;
    localparam logic [7:0] L3_MASK   = 8'hf0;
    localparam logic [7:0] L3_TAG    = 8'he0;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    // One command per accepted byte: buffer writes, plus the string end.
    typedef struct packed {
        logic              raw_we;
        logic [ADDR_W-1:0] raw_addr;
        logic [7:0]        raw_data;
        logic              char_we;
        logic [ADDR_W-1:0] char_addr;
        logic [15:0]       char_data;
        logic              is_end;
        logic [CNT_W-1:0]  count;
        logic              fb;
        logic              ovf;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage

`default_nettype wire

### hdl/utf8d_if.sv
// Handshake channels of the UTF-8 string decoder: byte input, character output.
// No dependencies.
`default_nettype none

interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_out;
    logic        last_char;
    logic        fell_back;
    logic        overflowed;

    modport source (output valid, output char_out, output last_char,
                    output fell_back, output overflowed, input ready);
    modport sink   (input valid, input char_out, input last_char,
                    input fell_back, input overflowed, output ready);
endinterface

`default_nettype wire

### hdl/utf8d_front.sv
// Front end: takes bytes, tracks UTF-8 sequence state, issues buffer commands.
// Depends on utf8d_pkg and utf8d_in_if.
`default_nettype none

module utf8d_front
    import utf8d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    utf8d_in_if.sink     i_byte,
    input  wire t_q_stat i_q_stat,
    output logic         o_push,
    output t_cmd         o_cmd
);

    logic [CNT_W-1:0]  r_byte_cnt, n_byte_cnt;
    logic [CNT_W-1:0]  r_char_cnt, n_char_cnt;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [15:0]       r_part, n_part;
    logic              r_mal, n_mal;
    logic              r_ovf, n_ovf;
    logic              w_acc;
    logic [7:0]        w_b;

    assign i_byte.ready = !i_q_stat.full;
    assign w_acc        = i_byte.valid && i_byte.ready;
    assign w_b          = i_byte.byte_in;
    assign o_push       = w_acc;

    always_comb begin
        n_byte_cnt = r_byte_cnt;
        n_char_cnt = r_char_cnt;
        n_pend     = r_pend;
        n_part     = r_part;
        n_mal      = r_mal;
        n_ovf      = r_ovf;

        o_cmd           = '0;
        o_cmd.raw_addr  = r_byte_cnt[ADDR_W-1:0];
        o_cmd.raw_data  = w_b;
        o_cmd.char_addr = r_char_cnt[ADDR_W-1:0];

        if (w_acc) begin
            if (r_byte_cnt < MAX_CNT) begin
                o_cmd.raw_we = 1'b1;
                n_byte_cnt   = r_byte_cnt + 1'b1;
                if (!r_mal) begin
                    if (r_pend != PEND_NONE) begin
                        if ((w_b & CONT_MASK) != CONT_TAG) begin
                            n_mal = 1'b1;
                        end else begin
                            n_pend = r_pend - 1'b1;
                            n_part = r_part | (n_pend[0] ? {4'b0, w_b[5:0], 6'b0}
                                                          : {10'b0, w_b[5:0]});
                            if (n_pend == PEND_NONE && r_char_cnt < MAX_CNT) begin
                                o_cmd.char_we   = 1'b1;
                                o_cmd.char_data = n_part;
                                n_char_cnt      = r_char_cnt + 1'b1;
                            end
                        end
                    end else if (!w_b[7]) begin
                        if (r_char_cnt < MAX_CNT) begin
                            o_cmd.char_we   = 1'b1;
                            o_cmd.char_data = {8'b0, w_b};
                            n_char_cnt      = r_char_cnt + 1'b1;
                        end
                    end else if ((w_b & L2_MASK) == L2_TAG) begin
                        n_part = {5'b0, w_b[4:0], 6'b0};
                        n_pend = PEND_ONE;
                    end else if ((w_b & L3_MASK) == L3_TAG) begin
                        n_part = {w_b[3:0], 12'b0};
                        n_pend = PEND_TWO;
                    end else begin
                        n_mal = 1'b1;
                    end
                end
            end else begin
                n_ovf = 1'b1;
            end

            if (i_byte.last_byte) begin
                // a sequence still open at the end makes the string malformed
                o_cmd.is_end = 1'b1;
                o_cmd.fb     = n_mal || (n_pend != PEND_NONE);
                o_cmd.count  = o_cmd.fb ? n_byte_cnt : n_char_cnt;
                o_cmd.ovf    = n_ovf;
                n_byte_cnt   = '0;
                n_char_cnt   = '0;
                n_pend       = PEND_NONE;
                n_part       = '0;
                n_mal        = 1'b0;
                n_ovf        = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_char_cnt <= '0;
            r_pend     <= PEND_NONE;
            r_part     <= '0;
            r_mal      <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_byte_cnt <= n_byte_cnt;
            r_char_cnt <= n_char_cnt;
            r_pend     <= n_pend;
            r_part     <= n_part;
            r_mal      <= n_mal;
            r_ovf      <= n_ovf;
        end
    end

endmodule

`default_nettype wire

### hdl/utf8d_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_cmd_fifo
    import utf8d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output t_cmd      o_data,
    output t_q_stat   o_stat
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_stat.full     = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_stat.nonempty = (r_cnt != '0);
    assign o_data          = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{Q_PTR_W{1'b0}}, i_push} - {{Q_PTR_W{1'b0}}, i_pop};
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

### hdl/utf8d_back.sv
// Back end: applies buffer writes, then streams a finished string out.
// Depends on utf8d_pkg and utf8d_out_if.
`default_nettype none

module utf8d_back
    import utf8d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_q_stat,
    input  wire t_cmd    i_cmd,
    output logic         o_pop,
    output logic         o_emitting,
    utf8d_out_if.source  o_char
);

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [15:0] char_out;
        logic        last_char;
        logic        fell_back;
        logic        overflowed;
    } t_ob;

    typedef struct packed {
        logic last;
        logic fb;
        logic ovf;
    } t_tag;

    logic [7:0]  raw_mem  [MAX_BYTES];
    logic [15:0] char_mem [MAX_BYTES];

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_fb, n_fb;
    logic             r_ovf, n_ovf;
    logic             r_rdv;
    t_tag             r_tag;
    logic [7:0]       r_raw_q;
    logic [15:0]      r_char_q;
    t_ob              r_ob [2];
    logic             r_ob_wp, r_ob_rp;
    logic [1:0]       r_ob_cnt;

    logic       w_out_xfer;
    logic       w_issue;
    logic       w_last_idx;
    logic [2:0] w_credit;
    t_ob        w_ob_in;

    assign o_pop      = (r_state == S_LOAD) && i_q_stat.nonempty;
    assign o_emitting = (r_state == S_EMIT);

    assign w_out_xfer = o_char.valid && o_char.ready;
    // slots still claimed after this cycle: queued, in flight, minus leaving
    assign w_credit   = {1'b0, r_ob_cnt} + {2'b0, r_rdv} - {2'b0, w_out_xfer};
    assign w_issue    = (r_state == S_EMIT) && (w_credit < 3'd2);
    assign w_last_idx = (r_idx == r_count - 1'b1);

    assign w_ob_in.char_out   = r_tag.fb ? {8'b0, r_raw_q} : r_char_q;
    assign w_ob_in.last_char  = r_tag.last;
    assign w_ob_in.fell_back  = r_tag.fb;
    assign w_ob_in.overflowed = r_tag.ovf;

    assign o_char.valid      = (r_ob_cnt != 2'd0);
    assign o_char.char_out   = r_ob[r_ob_rp].char_out;
    assign o_char.last_char  = r_ob[r_ob_rp].last_char;
    assign o_char.fell_back  = r_ob[r_ob_rp].fell_back;
    assign o_char.overflowed = r_ob[r_ob_rp].overflowed;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_fb    = r_fb;
        n_ovf   = r_ovf;
        case (r_state)
            S_LOAD: begin
                if (o_pop && i_cmd.is_end) begin
                    n_count = i_cmd.count;
                    n_fb    = i_cmd.fb;
                    n_ovf   = i_cmd.ovf;
                    n_idx   = '0;
                    if (i_cmd.count != '0) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                    if (w_last_idx) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Buffer writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.raw_we) begin
            raw_mem[i_cmd.raw_addr] <= i_cmd.raw_data;
        end
        if (o_pop && i_cmd.char_we) begin
            char_mem[i_cmd.char_addr] <= i_cmd.char_data;
        end
        if (w_issue) begin
            r_raw_q  <= raw_mem[r_idx[ADDR_W-1:0]];
            r_char_q <= char_mem[r_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_idx    <= '0;
            r_fb     <= 1'b0;
            r_ovf    <= 1'b0;
            r_rdv    <= 1'b0;
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_fb     <= n_fb;
            r_ovf    <= n_ovf;
            r_rdv    <= w_issue;
            if (r_rdv) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (w_out_xfer) begin
                r_ob_rp <= ~r_ob_rp;
            end
            r_ob_cnt <= r_ob_cnt + {1'b0, r_rdv} - {1'b0, w_out_xfer};
        end
        if (w_issue) begin
            r_tag.last <= w_last_idx;
            r_tag.fb   <= r_fb;
            r_tag.ovf  <= r_ovf;
        end
        if (r_rdv) begin
            r_ob[r_ob_wp] <= w_ob_in;
        end
    end

endmodule

`default_nettype wire

### hdl/utf8_string_decoder.sv
// UTF-8 string decoder top level; uses utf8d_pkg, utf8d_if, front, queue, back.
// Input: one byte per cycle while the four-entry command queue has room.
// Output: with the queue and the back end idle, the first character is valid
// once the final byte's transfer has passed the pop, the buffer read and the output
// register, then one character per cycle while the sink is ready (one buffer read per cycle in the back).
// The input stalls once the queue fills while the back streams a string out.
// Reset: synchronous, active low; clears control only, buffers are not cleared.
`default_nettype none

`include "utf8_string_decoder_macros.svh"

module utf8_string_decoder
    import utf8d_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    utf8d_in_if.sink    i_byte,
    utf8d_out_if.source o_char
);

    // Front end to queue: one command per accepted byte.
    logic    q_push;
    t_cmd    q_wr_data;
    // Queue to back end.
    logic    q_pop;
    t_cmd    q_rd_data;
    t_q_stat q_stat;
    // Back end is streaming a string out.
    logic    bk_emitting;
    // String end with at least one character leaves the queue.
    logic    q_end_pop;

    assign q_end_pop = q_pop && q_rd_data.is_end && (q_rd_data.count != '0);

    // Decode each byte as it arrives and turn it into buffer writes.
    utf8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_cmd    (q_wr_data)
    );

    // Decouple the two sides so bytes of the next string can queue up.
    utf8d_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_stat  (q_stat)
    );

    // Apply writes; on the string end, stream decoded or raw characters.
    utf8d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_cmd      (q_rd_data),
        .o_pop      (q_pop),
        .o_emitting (bk_emitting),
        .o_char     (o_char)
    );

    // Never push into a full queue.
    `UTF8D_ASSERT_NOW(a_q_no_overrun, q_push, !q_stat.full, "push into full command queue")
    // Hold the input off while the queue is full.
    `UTF8D_ASSERT_NOW(a_in_stall, q_stat.full, !i_byte.ready, "input ready with full queue")
    // Drain nothing from the queue while streaming a string out.
    `UTF8D_ASSERT_NOW(a_no_pop_emit, bk_emitting, !q_pop, "queue popped during emission")
    // A non-empty string end starts emission on the next cycle.
    `UTF8D_ASSERT_NEXT(a_end_starts_emit, q_end_pop, bk_emitting, "end did not start emission")

endmodule

`default_nettype wire

### bench/utf8_string_decoder_tb.sv
// Self-checking bench for utf8_string_decoder: byte strings in, characters out.
// Depends on utf8d_pkg and the utf8d_in_if / utf8d_out_if channel interfaces.
`default_nettype none

module utf8_string_decoder_tb;
    import utf8d_pkg::*;

    localparam int TARGET_BYTES = 410;
    localparam int IDLE_PCT     = 37;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [15:0] code;
        logic        last;
        logic        fb;
        logic        ovf;
    } char_rec_t;

    typedef enum int {FAULT_STRAY, FAULT_BAD_LEAD, FAULT_PARTIAL} fault_e;

    // Tracks the string being assembled and holds the characters it will emit.
    class utf8_string_tracker;
        logic [7:0]  raw_store [MAX_BYTES];
        logic [15:0] char_store[MAX_BYTES];
        int          byte_cnt;
        int          char_cnt;
        logic [1:0]  pend;
        logic [15:0] partial;
        bit          malformed;
        bit          ovf_seen;
        char_rec_t   pending_chars[$];
        int          bad_chars;

        function void clear_string();
            byte_cnt  = 0;
            char_cnt  = 0;
            pend      = PEND_NONE;
            partial   = 16'h0;
            malformed = 1'b0;
            ovf_seen  = 1'b0;
        endfunction

        function void push_char(logic [15:0] c);
            if (char_cnt < MAX_BYTES) begin
                char_store[char_cnt] = c;
                char_cnt++;
            end
        endfunction

        function void decode_byte(logic [7:0] b);
            if (pend != PEND_NONE) begin
                if ((b & CONT_MASK) != CONT_TAG) begin
                    malformed = 1'b1;
                    return;
                end
                pend    = pend - 2'd1;
                partial = partial | (16'(b[5:0]) << (6 * pend));
                if (pend == PEND_NONE)
                    push_char(partial);
                return;
            end
            if (!b[7]) begin
                push_char({8'h00, b});
            end else if ((b & L2_MASK) == L2_TAG) begin
                partial = {5'b0, b[4:0], 6'b0};
                pend    = PEND_ONE;
            end else if ((b & L3_MASK) == L3_TAG) begin
                partial = {b[3:0], 12'b0};
                pend    = PEND_TWO;
            end else begin
                malformed = 1'b1;
            end
        endfunction

        // Take one accepted byte; on the final byte queue the whole string.
        function void note_byte(logic [7:0] b, logic last);
            int        n;
            char_rec_t rec;
            if (byte_cnt < MAX_BYTES) begin
                raw_store[byte_cnt] = b;
                byte_cnt++;
                if (!malformed)
                    decode_byte(b);
            end else begin
                ovf_seen = 1'b1;
            end
            if (!last)
                return;
            if (pend != PEND_NONE)
                malformed = 1'b1;
            n = malformed ? byte_cnt : char_cnt;
            for (int k = 0; k < n; k++) begin
                rec.code = malformed ? {8'h00, raw_store[k]} : char_store[k];
                rec.last = (k == n - 1);
                rec.fb   = malformed;
                rec.ovf  = ovf_seen;
                pending_chars.push_back(rec);
            end
            clear_string();
        endfunction

        function void check_char(char_rec_t got);
            char_rec_t exp;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char expected none got %h/%b/%b/%b",
                         $time, got.code, got.last, got.fb, got.ovf);
                bad_chars++;
                return;
            end
            exp = pending_chars.pop_front();
            if (got.code !== exp.code)
                $display("%0t: char_out expected %h got %h", $time, exp.code, got.code);
            if (got.last !== exp.last)
                $display("%0t: last_char expected %b got %b", $time, exp.last, got.last);
            if (got.fb !== exp.fb)
                $display("%0t: fell_back expected %b got %b", $time, exp.fb, got.fb);
            if (got.ovf !== exp.ovf)
                $display("%0t: overflowed expected %b got %b", $time, exp.ovf, got.ovf);
            if (got !== exp)
                bad_chars++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   items_sent;
    int   stall_cycles;

    logic [7:0]         str_bytes[$];
    utf8_string_tracker tracker;

    utf8d_in_if  in_ch();
    utf8d_out_if out_ch();

    utf8_string_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (in_ch),
        .o_char  (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Sink side: check every transfer, then pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_char({out_ch.char_out, out_ch.last_char,
                                out_ch.fell_back, out_ch.overflowed});
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Abort when neither channel has moved a transfer for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("utf8_string_decoder: mismatch");
                $finish;
            end
        end
    end

    // Offer one byte, with random gaps before it, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.byte_in   <= b;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.note_byte(b, last);
        items_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // Append one well-formed character of nbytes bytes with random payload bits.
    task automatic add_char(input int nbytes);
        case (nbytes)
            1: str_bytes.push_back({1'b0, 7'($urandom)});
            2: begin
                str_bytes.push_back({3'b110, 5'($urandom)});
                str_bytes.push_back({2'b10, 6'($urandom)});
            end
            default: begin
                str_bytes.push_back({4'b1110, 4'($urandom)});
                str_bytes.push_back({2'b10, 6'($urandom)});
                str_bytes.push_back({2'b10, 6'($urandom)});
            end
        endcase
    endtask

    // Append a broken piece; a partial sequence becomes interrupted or truncated
    // depending on what follows it.
    task automatic add_fault(input fault_e kind);
        case (kind)
            FAULT_STRAY:    str_bytes.push_back({2'b10, 6'($urandom)});
            FAULT_BAD_LEAD: str_bytes.push_back({5'b11110, 3'($urandom)} | 8'($urandom_range(1) << 3));
            default: begin
                if ($urandom_range(1)) begin
                    str_bytes.push_back({3'b110, 5'($urandom)});
                end else begin
                    str_bytes.push_back({4'b1110, 4'($urandom)});
                    if ($urandom_range(1))
                        str_bytes.push_back({2'b10, 6'($urandom)});
                end
            end
        endcase
    endtask

    // Mostly well-formed strings; a few long ones reach close to or past the buffer size,
    // some carry a fault, and some are pure noise.
    task automatic build_random_string(input bit force_long);
        int mode;
        int nchars;
        int fault_at;
        int target;
        str_bytes.delete();
        mode = $urandom_range(99);
        if (force_long || mode < 4) begin
            target = $urandom_range(70, 62);
            while (str_bytes.size() < target)
                add_char($urandom_range(3, 1));
            return;
        end
        if (mode < 10) begin
            nchars = $urandom_range(12, 1);
            repeat (nchars) str_bytes.push_back(8'($urandom));
            return;
        end
        nchars   = $urandom_range(10, 1);
        fault_at = (mode < 35) ? $urandom_range(nchars, 0) : -1;
        for (int k = 0; k < nchars; k++) begin
            if (k == fault_at)
                add_fault(fault_e'($urandom_range(2)));
            add_char($urandom_range(3, 1));
        end
        if (fault_at == nchars)
            add_fault(fault_e'($urandom_range(2)));
    endtask

    initial begin
        int strings_done;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.byte_in   = 8'h00;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        no_idle         = 1'b0;
        items_sent      = 0;
        stall_cycles    = 0;
        strings_done    = 0;
        tracker         = new();
        tracker.clear_string();
        tracker.bad_chars = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: one-byte string, ASCII extremes, two- and three-byte
        // forms including an overlong one, a stray continuation followed by
        // valid bytes, a four-byte lead next to 0xff, an interrupted sequence,
        // a truncated tail and the largest two-byte character.
        str_bytes = '{8'h41};                               send_string();
        str_bytes = '{8'h00, 8'h7f};                        send_string();
        str_bytes = '{8'hc2, 8'ha9, 8'he2, 8'h82, 8'hac};   send_string();
        str_bytes = '{8'hef, 8'hbf, 8'hbf, 8'hc0, 8'h80};   send_string();
        str_bytes = '{8'h80, 8'hc3, 8'ha9};                 send_string();
        str_bytes = '{8'hf0, 8'hff};                        send_string();
        str_bytes = '{8'hc3, 8'h41};                        send_string();
        str_bytes = '{8'he2, 8'h82};                        send_string();
        str_bytes = '{8'hdf, 8'hbf};                        send_string();

        // Random strings; drop the idling on both sides for a middle stretch.
        while (items_sent < TARGET_BYTES) begin
            no_idle <= (items_sent >= 150 && items_sent < 260);
            build_random_string(strings_done == 3);
            send_string();
            strings_done++;
        end
        in_ch.valid <= 1'b0;

        // Hold until every queued character has come back, then let it settle.
        while (tracker.pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.bad_chars == 0)
            $display("utf8_string_decoder: match");
        else
            $display("utf8_string_decoder: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
